// ===== rtl/caf_pkg.sv =====
// Shared constants and types for the complementary attitude filter.
package caf_pkg;

    localparam int unsigned RegWidth    = 16;
    localparam int unsigned InWidth     = 16;
    localparam int unsigned AngleWidth  = 32;
    localparam int unsigned RegIdxWidth = 2;

    localparam logic [RegIdxWidth-1:0] REG_SAMPLE_TIME  = 2'd0;
    localparam logic [RegIdxWidth-1:0] REG_GYRO_WEIGHT  = 2'd1;
    localparam logic [RegIdxWidth-1:0] REG_ACCEL_WEIGHT = 2'd2;

    localparam logic [RegWidth-1:0] SampleTimeReset  = 16'd655;
    localparam logic [RegWidth-1:0] GyroWeightReset  = 16'd32113;
    localparam logic [RegWidth-1:0] AccelWeightReset = 16'd655;

    // Degrees per radian in Q.20.
    localparam logic [25:0] DegPerRadQ20 = 26'd60078979;
    localparam logic signed [AngleWidth-1:0] Deg90Q16  = 32'sd5898240;
    localparam logic signed [AngleWidth-1:0] Deg180Q16 = 32'sd11796480;

    localparam logic signed [AngleWidth-1:0] SatMax = 32'sh7FFF_FFFF;
    localparam logic signed [AngleWidth-1:0] SatMin = -32'sh8000_0000;

    // Quotient width: num*K < 2^30*... magnitude of R(q) below 2^23.
    localparam int unsigned QuoWidth = 24;
    localparam int unsigned NumWidth = 64;
    localparam int unsigned DenWidth = 41;

    typedef struct packed {
        logic signed [InWidth-1:0] rate_x;
        logic signed [InWidth-1:0] rate_y;
        logic signed [InWidth-1:0] rate_z;
        logic signed [InWidth-1:0] acc_x;
        logic signed [InWidth-1:0] acc_y;
        logic signed [InWidth-1:0] acc_z;
    } caf_in_t;

    typedef struct packed {
        logic signed [AngleWidth-1:0] roll_out;
        logic signed [AngleWidth-1:0] pitch_out;
        logic signed [AngleWidth-1:0] yaw_out;
    } caf_out_t;

    function automatic logic signed [AngleWidth-1:0] sat32(input logic signed [49:0] v);
        if (v > 50'(SatMax)) return SatMax;
        if (v < 50'(SatMin)) return SatMin;
        return v[AngleWidth-1:0];
    endfunction

endpackage

// ===== rtl/caf_stream_if.sv =====
// Valid/ready channel carrying one payload beat.
interface caf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/caf_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module caf_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [caf_pkg::NumWidth-1:0]  num,
    input  logic [caf_pkg::DenWidth-1:0]  den,
    output logic                          done,
    output logic [caf_pkg::QuoWidth-1:0]  quo
);
    import caf_pkg::*;

    localparam int unsigned CntWidth = $clog2(QuoWidth + 1);

    // Quotient is known to fit in QuoWidth bits, so shift the divisor up.
    logic [DenWidth+QuoWidth-1:0] rem_reg, rem_next;
    logic [DenWidth+QuoWidth-1:0] dsr_reg, dsr_next;
    logic [QuoWidth-1:0]          quo_reg, quo_next;
    logic [CntWidth-1:0]          cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = (DenWidth+QuoWidth)'(num);
            dsr_next  = {den, {QuoWidth-1{1'b0}}, 1'b0} >> 1;
            cnt_next  = CntWidth'(QuoWidth);
            busy_next = 1'b1;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_next = rem_reg - dsr_reg;
                quo_next = {quo_reg[QuoWidth-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QuoWidth-2:0], 1'b0};
            end
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ===== rtl/complementary_attitude_filter_unit.sv =====
// Complementary attitude filter: gyro integration blended with accelerometer tilt.
// Each tilt angle runs setup, multiply, divider load, 24 bit-serial steps, done and finish;
// a zero acc_z skips both divides.
// One sample at a time: the next input beat waits for the result beat.
// Reset: angles clear to zero, registers load their defaults, output invalid.
module complementary_attitude_filter_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    caf_stream_if.sink                           in_ch,
    caf_stream_if.source                         out_ch,
    input  logic                                 cfg_we,
    input  logic [caf_pkg::RegIdxWidth-1:0]      cfg_index,
    input  logic [caf_pkg::RegWidth-1:0]         cfg_data
);
    import caf_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_INTEG  = 11'b000_0000_0010,
        ST_TSET   = 11'b000_0000_0100,
        ST_TMUL   = 11'b000_0000_1000,
        ST_TDIV   = 11'b000_0001_0000,
        ST_TWAIT  = 11'b000_0010_0000,
        ST_TFIN   = 11'b000_0100_0000,
        ST_BLEND1 = 11'b000_1000_0000,
        ST_BLEND2 = 11'b001_0000_0000,
        ST_BLEND3 = 11'b010_0000_0000,
        ST_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [RegWidth-1:0] st_reg, gw_reg, aw_reg;
    logic signed [AngleWidth-1:0] roll_reg, pitch_reg, yaw_reg;
    caf_in_t smp_reg;
    logic    pass_reg;                           // 0: roll tilt, 1: pitch tilt
    logic signed [InWidth:0]    ta_reg, tb_reg;  // operands of current tilt
    logic signed [35:0]         nab_reg;         // 25ab
    logic [35:0]                den_reg;         // 25x^2+7y^2
    logic                       small_reg;       // |a| < |b|
    logic signed [AngleWidth-1:0] racc_reg, pacc_reg;
    logic signed [49:0]         prod_reg;

    // Divider hookup
    logic div_start, div_done;
    logic [NumWidth-1:0] div_num;
    logic [DenWidth-1:0] div_den;
    logic [QuoWidth-1:0] div_quo;

    caf_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Integration deltas (three 16x16 products, one per angle)
    function automatic logic signed [AngleWidth-1:0] integ(
        input logic signed [InWidth-1:0] r, input logic [RegWidth-1:0] t);
        logic signed [33:0] p;
        p = 34'(r) * $signed({1'b0, t}) + 34'sd128;
        return AngleWidth'(p >>> 8);
    endfunction

    logic signed [AngleWidth-1:0] yaw_delta_c;

    // Magnitudes and tilt terms
    logic [InWidth:0]  abs_a, abs_b;
    logic [35:0]       mag_num;
    logic [63:0]       num_scaled;
    logic signed [AngleWidth-1:0] r_signed;
    logic signed [AngleWidth-1:0] tilt_c;

    always_comb
    begin
        abs_a = ta_reg[InWidth] ? 17'(-ta_reg) : 17'(ta_reg);
        abs_b = tb_reg[InWidth] ? 17'(-tb_reg) : 17'(tb_reg);
        mag_num = nab_reg[35] ? 36'(-nab_reg) : 36'(nab_reg);
        // num*K/(16 den) rounded: (2*num*K + 16den) / (32den)
        num_scaled = 64'(mag_num) * 64'(DegPerRadQ20);
        div_num = {num_scaled[62:0], 1'b0} + 64'({den_reg, 4'b0});
        div_den = DenWidth'({den_reg, 5'b0});
        r_signed = nab_reg[35] ? -AngleWidth'(div_quo) : AngleWidth'(div_quo);
        yaw_delta_c = integ(smp_reg.rate_z, st_reg);
        if (tb_reg == '0)
        begin
            if (ta_reg > 0)       tilt_c = Deg90Q16;
            else if (ta_reg == 0) tilt_c = '0;
            else                  tilt_c = -Deg90Q16;
        end
        else if (small_reg)
        begin
            if (tb_reg < 0)
                tilt_c = ta_reg < 0 ? r_signed - Deg180Q16 : r_signed + Deg180Q16;
            else
                tilt_c = r_signed;
        end
        else
        begin
            tilt_c = Deg90Q16 - r_signed;
            if (ta_reg < 0) tilt_c = tilt_c - Deg180Q16;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:   if (in_ch.valid) state_next = ST_INTEG;
            ST_INTEG:  state_next = ST_TSET;
            ST_TSET:   state_next = ST_TMUL;
            ST_TMUL:   state_next = (tb_reg == '0) ? ST_TFIN : ST_TDIV;
            ST_TDIV:
            begin
                div_start  = 1'b1;
                state_next = ST_TWAIT;
            end
            ST_TWAIT:  if (div_done) state_next = ST_TFIN;
            ST_TFIN:   state_next = pass_reg ? ST_BLEND1 : ST_TSET;
            ST_BLEND1: state_next = ST_BLEND2;
            ST_BLEND2: state_next = ST_BLEND3;
            ST_BLEND3: state_next = ST_OUT;
            ST_OUT:    if (out_ch.ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.data  = '{roll_out: roll_reg, pitch_out: pitch_reg, yaw_out: yaw_reg};

    logic signed [33:0] aa_sq, bb_sq;
    logic signed [49:0] blend_c;
    always_comb
    begin
        aa_sq   = 34'(ta_reg) * 34'(ta_reg);
        bb_sq   = 34'(tb_reg) * 34'(tb_reg);
        blend_c = (prod_reg + 50'sd16384) >>> 15;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            st_reg    <= SampleTimeReset;
            gw_reg    <= GyroWeightReset;
            aw_reg    <= AccelWeightReset;
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
            pass_reg  <= 1'b0;
            racc_reg  <= '0;
            pacc_reg  <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SAMPLE_TIME:  st_reg <= cfg_data;
                    REG_GYRO_WEIGHT:  gw_reg <= cfg_data;
                    REG_ACCEL_WEIGHT: aw_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_INTEG:
                begin
                    roll_reg  <= sat32(50'(roll_reg) + 50'(integ(smp_reg.rate_x, st_reg)));
                    pitch_reg <= sat32(50'(pitch_reg) - 50'(integ(smp_reg.rate_y, st_reg)));
                    yaw_reg   <= sat32(50'(yaw_reg) + 50'(yaw_delta_c));
                    pass_reg  <= 1'b0;
                end
                ST_TFIN:
                begin
                    pass_reg <= 1'b1;
                    if (pass_reg) pacc_reg <= tilt_c;
                    else          racc_reg <= tilt_c;
                end
                ST_BLEND1:
                    // Roll: gyro part then accel part
                    prod_reg <= 50'(roll_reg) * $signed({1'b0, gw_reg})
                              + 50'(racc_reg) * $signed({1'b0, aw_reg});
                ST_BLEND2:
                begin
                    roll_reg <= sat32(blend_c);
                    prod_reg <= 50'(pitch_reg) * $signed({1'b0, gw_reg})
                              - 50'(pacc_reg) * $signed({1'b0, aw_reg});
                end
                ST_BLEND3: pitch_reg <= sat32(blend_c);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
            smp_reg <= in_ch.data;
        if (state_reg == ST_TSET)
        begin
            ta_reg <= pass_reg ? 17'(smp_reg.acc_x) : 17'(smp_reg.acc_y);
            tb_reg <= 17'(smp_reg.acc_z);
        end
        if (state_reg == ST_TMUL)
        begin
            small_reg <= abs_a < abs_b;
            nab_reg   <= 36'sd25 * 36'(ta_reg) * 36'(tb_reg);
            den_reg   <= (abs_a < abs_b)
                         ? 36'(36'sd25 * 36'(bb_sq) + 36'sd7 * 36'(aa_sq))
                         : 36'(36'sd25 * 36'(aa_sq) + 36'sd7 * 36'(bb_sq));
        end
    end
endmodule

// ===== tb/caf_filter_checker.sv =====
// Checker for the attitude filter: predicts angles per sample and compares result beats.
module caf_filter_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  caf_pkg::caf_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  caf_pkg::caf_out_t out_data,
    input  logic              cfg_we,
    input  logic [caf_pkg::RegIdxWidth-1:0] cfg_index,
    input  logic [caf_pkg::RegWidth-1:0]    cfg_data,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import caf_pkg::*;

    logic [RegWidth-1:0] st_reg;
    logic [RegWidth-1:0] gw_reg;
    logic [RegWidth-1:0] aw_reg;
    logic signed [AngleWidth-1:0] roll_q;
    logic signed [AngleWidth-1:0] pitch_q;
    logic signed [AngleWidth-1:0] yaw_q;
    caf_out_t angle_queue[$];

    assign pending = angle_queue.size();

    function automatic logic signed [AngleWidth-1:0] clamp32(input longint v);
        if (v > longint'(SatMax)) return SatMax;
        if (v < longint'(SatMin)) return SatMin;
        return v[AngleWidth-1:0];
    endfunction

    // degrees Q16.16 of num/den radians, rounded half away from zero
    function automatic longint rad_ratio_deg(input longint num, input longint den);
        longint n;
        longint d;
        n = num * 64'sd60078979;
        d = den * 16;
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint tilt_q16(input longint a, input longint b);
        longint aa;
        longint ab;
        longint t;
        aa = (a < 0) ? -a : a;
        ab = (b < 0) ? -b : b;
        if (b == 0) begin
            if (a > 0) return longint'(Deg90Q16);
            if (a == 0) return 0;
            return -longint'(Deg90Q16);
        end
        if (aa < ab) begin
            t = rad_ratio_deg(25 * a * b, 25 * b * b + 7 * a * a);
            if (b < 0) return (a < 0) ? t - longint'(Deg180Q16) : t + longint'(Deg180Q16);
            return t;
        end
        t = longint'(Deg90Q16) - rad_ratio_deg(25 * a * b, 25 * a * a + 7 * b * b);
        if (a < 0) t -= longint'(Deg180Q16);
        return t;
    endfunction

    function automatic longint rate_step(input logic signed [InWidth-1:0] rate);
        return (longint'(rate) * longint'(st_reg) + 128) >>> 8;
    endfunction

    task automatic update_angles(input caf_in_t s, output caf_out_t r);
        longint roll_tilt;
        longint pitch_tilt;
        logic signed [AngleWidth-1:0] rl;
        logic signed [AngleWidth-1:0] pt;
        logic signed [AngleWidth-1:0] yw;
        rl = clamp32(longint'(roll_q) + rate_step(s.rate_x));
        pt = clamp32(longint'(pitch_q) - rate_step(s.rate_y));
        yw = clamp32(longint'(yaw_q) + rate_step(s.rate_z));
        roll_tilt  = tilt_q16(longint'(s.acc_y), longint'(s.acc_z));
        pitch_tilt = tilt_q16(longint'(s.acc_x), longint'(s.acc_z));
        rl = clamp32((longint'(rl) * longint'(gw_reg)
                      + roll_tilt * longint'(aw_reg) + 16384) >>> 15);
        pt = clamp32((longint'(pt) * longint'(gw_reg)
                      - pitch_tilt * longint'(aw_reg) + 16384) >>> 15);
        roll_q  = rl;
        pitch_q = pt;
        yaw_q   = yw;
        r.roll_out  = rl;
        r.pitch_out = pt;
        r.yaw_out   = yw;
    endtask

    task automatic report(input string field, input logic signed [31:0] exp_v,
                          input logic signed [31:0] got_v);
        if (errors < 10)
            $display("%0t: %s expected %0d got %0d", $realtime, field, exp_v, got_v);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        caf_out_t want;
        caf_out_t got;
        if (!rst_n) begin
            st_reg  <= SampleTimeReset;
            gw_reg  <= GyroWeightReset;
            aw_reg  <= AccelWeightReset;
            roll_q  = '0;
            pitch_q = '0;
            yaw_q   = '0;
            errors  = 0;
            angle_queue.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SAMPLE_TIME:  st_reg <= cfg_data;
                    REG_GYRO_WEIGHT:  gw_reg <= cfg_data;
                    REG_ACCEL_WEIGHT: aw_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                got = out_data;
                if (angle_queue.size() == 0) begin
                    if (errors < 10) $display("%0t: result beat with none expected", $realtime);
                    errors++;
                end else begin
                    want = angle_queue.pop_front();
                    if (got.roll_out !== want.roll_out)
                        report("roll", want.roll_out, got.roll_out);
                    if (got.pitch_out !== want.pitch_out)
                        report("pitch", want.pitch_out, got.pitch_out);
                    if (got.yaw_out !== want.yaw_out)
                        report("yaw", want.yaw_out, got.yaw_out);
                end
            end
            if (in_valid && in_ready) begin
                update_angles(in_data, want);
                angle_queue.push_back(want);
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
// Top of the attitude filter testbench: clock, reset, stimulus, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import caf_pkg::*;

    localparam int StallLimit = 3000;
    localparam int HoldCycles = 400;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [RegIdxWidth-1:0] cfg_index;
    logic [RegWidth-1:0] cfg_data;
    int errors;
    int pending;
    int quiet_cycles = 0;
    bit steady;       // no idling on either side
    bit hold_req;
    bit hold_done;

    caf_stream_if #(.payload_t(caf_in_t))  in_ch ();
    caf_stream_if #(.payload_t(caf_out_t)) out_ch ();

    complementary_attitude_filter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    caf_filter_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_data   (in_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_ch.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // result side: random stalls, one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_ch.ready = 1'b0;
                repeat (HoldCycles - 1) @(negedge clk);
                hold_done = 1'b1;
            end else begin
                out_ch.ready = steady || ($urandom_range(99) >= 25);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_sample(input caf_in_t s);
        while (!steady && $urandom_range(99) < 25) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = s;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // write only once the filter has drained
    task automatic write_reg(input logic [RegIdxWidth-1:0] idx, input logic [RegWidth-1:0] val);
        in_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (100) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] pick_field(input int mode);
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(8)) - 4);
            default: return (mode == 0) ? 16'($urandom)
                                        : 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    function automatic caf_in_t random_sample();
        caf_in_t s;
        int mode;
        mode = $urandom_range(1);
        s.rate_x = pick_field(mode);
        s.rate_y = pick_field(mode);
        s.rate_z = pick_field(mode);
        s.acc_x  = pick_field(mode);
        s.acc_y  = pick_field(mode);
        s.acc_z  = pick_field(mode);
        return s;
    endfunction

    function automatic caf_in_t mk(input int rx, ry, rz, ax, ay, az);
        caf_in_t s;
        s.rate_x = 16'(rx);
        s.rate_y = 16'(ry);
        s.rate_z = 16'(rz);
        s.acc_x  = 16'(ax);
        s.acc_y  = 16'(ay);
        s.acc_z  = 16'(az);
        return s;
    endfunction

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && !hold_req) hold_req = 1'b1;
            steady = (i >= 40 && i < 80);
            send_sample(random_sample());
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        steady = 1'b0;
        hold_req = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: axis extremes, quadrants, zero denominators, all-zero accel
        send_sample(mk(0, 0, 0, 0, 0, 0));
        send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767));
        send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        send_sample(mk(256, -256, 512, 100, 0, 0));
        send_sample(mk(0, 0, 0, -100, 5, 0));
        send_sample(mk(0, 0, 0, 0, -5, 0));
        send_sample(mk(0, 0, 0, 3, 4, 100));
        send_sample(mk(0, 0, 0, -3, -4, 100));
        send_sample(mk(0, 0, 0, 3, 4, -100));
        send_sample(mk(0, 0, 0, -3, -4, -100));
        send_sample(mk(0, 0, 0, 100, 100, 100));
        send_sample(mk(0, 0, 0, -100, -100, 100));
        send_sample(mk(0, 0, 0, 200, -300, -10));
        send_sample(mk(0, 0, 0, -32768, 32767, 1));
        send_sample(mk(-1, 1, -1, 1, -1, 16384));
        random_run(150);

        write_reg(REG_SAMPLE_TIME, 16'd65535);
        write_reg(REG_GYRO_WEIGHT, 16'd32768);
        write_reg(REG_ACCEL_WEIGHT, 16'd0);
        write_reg(2'd3, 16'hFFFF);
        random_run(150);

        write_reg(REG_SAMPLE_TIME, 16'd1);
        write_reg(REG_GYRO_WEIGHT, 16'd0);
        write_reg(REG_ACCEL_WEIGHT, 16'd32768);
        random_run(140);

        // zero sample time: no integration; gains above one saturate
        write_reg(REG_SAMPLE_TIME, 16'd0);
        write_reg(REG_GYRO_WEIGHT, 16'd65535);
        write_reg(REG_ACCEL_WEIGHT, 16'd65535);
        random_run(140);

        write_reg(REG_SAMPLE_TIME, 16'($urandom_range(65535, 1)));
        write_reg(REG_GYRO_WEIGHT, 16'($urandom_range(32768)));
        write_reg(REG_ACCEL_WEIGHT, 16'($urandom_range(32768)));
        random_run(150);

        write_reg(REG_SAMPLE_TIME, SampleTimeReset);
        write_reg(REG_GYRO_WEIGHT, GyroWeightReset);
        write_reg(REG_ACCEL_WEIGHT, AccelWeightReset);
        random_run(150);

        in_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
